// ===== hw/rtl/sv2oe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the state vector to orbit elements block.
// No dependencies; every other file imports this package.
package sv2oe_pkg;

    localparam int CORDIC_STAGES = 16;

    localparam int MUL_LAT   = 2;
    localparam int DIV_NUM_W = 128;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_LAT   = DIV_NUM_W;
    localparam int SQRT_LAT  = 32;

    localparam logic [47:0] MU_RESET = 48'd65536;
    localparam logic [31:0] INV_GAIN = 32'd2608131497;
    localparam logic [17:0] ECC_MAX  = 18'h3FFFF;

    // Pipeline stage numbers (stage 1 holds the accepted item)
    localparam int S_HM   = 3;
    localparam int S_R    = S_HM + SQRT_LAT;
    localparam int S_Q    = S_R + MUL_LAT;
    localparam int S_T2   = S_Q + DIV_LAT;
    localparam int S_HV   = S_T2 - MUL_LAT;
    localparam int S_A    = S_T2 + 1;
    localparam int S_N    = S_A + 1;
    localparam int S_C    = S_N + 1;
    localparam int S_G0   = S_C + CORDIC_STAGES;
    localparam int S_G    = S_G0 + MUL_LAT;
    localparam int S_GS   = S_G + 1;
    localparam int S_E0   = S_GS + DIV_LAT;
    localparam int S_E    = S_E0 + 1;
    localparam int S_E2   = S_E + 1;
    localparam int S_D    = S_E2 + 1;
    localparam int S_M    = S_D + DIV_LAT;
    localparam int S_O    = S_M + 1;
    localparam int S_LAT0 = S_HM + MUL_LAT + DIV_LAT;
    localparam int S_LAT  = S_LAT0 + 1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SAT         = 3'd1,
        ST_PARABOLIC   = 3'd2,
        ST_ZERO_RADIUS = 3'd3,
        ST_ZERO_MU     = 3'd4
    } t_status;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    localparam logic [31:0] ANGLE_STEP [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    function automatic logic [31:0] angle_step(int i);
        logic [31:0] v;
        v = '0;
        if (i < 32) begin
            v = ANGLE_STEP[i[4:0]];
        end
        return v;
    endfunction

    // Magnitude of a two's complement word; the most negative value maps to 2^31
    function automatic logic [31:0] abs32(logic [31:0] u);
        return u[31] ? (~u + 32'd1) : u;
    endfunction

    // Add two sign-magnitude values
    function automatic t_sm sm_add(logic n1, logic [63:0] m1, logic n2, logic [63:0] m2);
        t_sm r;
        if (n1 == n2) begin
            r.neg = n1;
            r.mag = m1 + m2;
        end else if (m1 >= m2) begin
            r.neg = n1;
            r.mag = m1 - m2;
        end else begin
            r.neg = n2;
            r.mag = m2 - m1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sv2oe_mul.sv =====
`timescale 1ns / 1ps
// 64 x 64 unsigned multiplier, two register stages: partial products, then sum.
// Depends on sv2oe_pkg.
module sv2oe_mul import sv2oe_pkg::*; (
    input  logic         i_clk,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_prod
);

    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_p00 <= i_a[31:0]  * i_b[31:0];
        r_p01 <= i_a[31:0]  * i_b[63:32];
        r_p10 <= i_a[63:32] * i_b[31:0];
        r_p11 <= i_a[63:32] * i_b[63:32];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                + {r_p11, 64'd0};
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/sv2oe_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on sv2oe_pkg for its widths and latency.
module sv2oe_div import sv2oe_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quo
);

    // numerator bits shift out at the top while quotient bits shift in below
    logic [DIV_NUM_W-1:0] r_nq  [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] r_rem [0:DIV_LAT-1];
    logic [DIV_DEN_W-1:0] r_den [0:DIV_LAT-1];

    genvar k;
    generate
        for (k = 0; k < DIV_LAT; k++) begin : g_stage
            logic [DIV_NUM_W-1:0] nq_in;
            logic [DIV_DEN_W-1:0] rem_in, den_in;
            logic [DIV_DEN_W:0]   trial, diff;
            logic                 ge;

            if (k == 0) begin : g_first
                assign nq_in  = i_num;
                assign rem_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign nq_in  = r_nq[k-1];
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
            end

            assign trial = {rem_in, nq_in[DIV_NUM_W-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = trial >= {1'b0, den_in};

            always_ff @(posedge i_clk) begin
                r_nq[k]  <= {nq_in[DIV_NUM_W-2:0], ge};
                r_rem[k] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                r_den[k] <= den_in;
            end
        end
    endgenerate

    assign o_quo = r_nq[DIV_LAT-1];

endmodule

// ===== hw/rtl/sv2oe_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root of a 64-bit value, two radicand bits per stage.
// Depends on sv2oe_pkg for its latency.
module sv2oe_sqrt import sv2oe_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    logic [63:0] r_n   [0:SQRT_LAT-1];
    logic [63:0] r_res [0:SQRT_LAT-1];

    genvar k;
    generate
        for (k = 0; k < SQRT_LAT; k++) begin : g_stage
            localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
            logic [63:0] n_in, res_in, trial;

            if (k == 0) begin : g_first
                assign n_in   = i_val;
                assign res_in = '0;
            end else begin : g_next
                assign n_in   = r_n[k-1];
                assign res_in = r_res[k-1];
            end

            assign trial = res_in + BITV;

            always_ff @(posedge i_clk) begin
                if (n_in >= trial) begin
                    r_n[k]   <= n_in - trial;
                    r_res[k] <= (res_in >> 1) + BITV;
                end else begin
                    r_n[k]   <= n_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQRT_LAT-1][31:0];

endmodule

// ===== hw/rtl/sv2oe_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring: drives y toward zero, gathers the angle in z.
// Depends on sv2oe_pkg for the stage count and angle steps.
module sv2oe_cordic import sv2oe_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    input  logic [31:0] i_z,
    output logic [63:0] o_x,
    output logic [31:0] o_z
);

    logic signed [63:0] r_x [0:CORDIC_STAGES-1];
    logic signed [63:0] r_y [0:CORDIC_STAGES-1];
    logic        [31:0] r_z [0:CORDIC_STAGES-1];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
            localparam logic [31:0] STEP = angle_step(i);
            logic signed [63:0] x_in, y_in, dx, dy;
            logic        [31:0] z_in;

            if (i == 0) begin : g_first
                assign x_in = i_x;
                assign y_in = i_y;
                assign z_in = i_z;
            end else begin : g_next
                assign x_in = r_x[i-1];
                assign y_in = r_y[i-1];
                assign z_in = r_z[i-1];
            end

            assign dx = y_in >>> i;
            assign dy = x_in >>> i;

            always_ff @(posedge i_clk) begin
                if (y_in[63]) begin
                    r_x[i] <= x_in - dx;
                    r_y[i] <= y_in + dy;
                    r_z[i] <= z_in - STEP;
                end else begin
                    r_x[i] <= x_in + dx;
                    r_y[i] <= y_in - dy;
                    r_z[i] <= z_in + STEP;
                end
            end
        end
    endgenerate

    assign o_x = r_x[CORDIC_STAGES-1];
    assign o_z = r_z[CORDIC_STAGES-1];

endmodule

// ===== hw/rtl/state_vector_to_orbit_elements.sv =====
`timescale 1ns / 1ps
// Planar state vector to orbital elements, fully pipelined fixed-point datapath.
// Depends on sv2oe_pkg, sv2oe_mul, sv2oe_div, sv2oe_sqrt and sv2oe_cordic.
//
// Usage:
//   Command channel: raise start with the position and velocity on the i_pos_* and
//   i_vel_* ports; the transfer happens at the clock edge where start is high and
//   busy is low. busy is high only while reset is held, so a new item may enter
//   on every cycle.
//   Result channel: o_valid strobes for one cycle with the elements on o_*. The
//   receiver cannot hold results off and takes each one in that cycle.
//   Throughput is one item per cycle. The latency is set by the chain of three
//   dependent long divisions (mu*p/r, length/mu, p/(1-e^2)), each a 128-stage
//   divider, plus the square root (32 stages), CORDIC (16 stages) and the short
//   multiply and add stages between them; h^2/mu runs alongside that chain.
//   Configuration: the mu register is written through i_cfg_data when i_cfg_valid
//   is high; o_cfg_ready is always high. Write it only with no item in flight.
//   Reset (synchronous, active low) clears all in-flight valid bits, drops any
//   item in flight, and sets mu back to 1.0.
module state_vector_to_orbit_elements import sv2oe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [47:0] i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_periapsis_angle,
    output logic        [31:0] o_latus_rectum,
    output logic        [17:0] o_eccentricity,
    output logic signed [31:0] o_major_semi_axis,
    output logic        [2:0]  o_status
);

    // Delay line lengths: each line carries data from one stage to a later one
    localparam int L1_N  = S_R - S_HM;
    localparam int L2_N  = S_Q - S_R;
    localparam int L3_N  = S_HV - S_HM;
    localparam int L4_N  = S_T2 - S_HV;
    localparam int L5_N  = S_M - S_N;
    localparam int L6_N  = S_M - S_G0;
    localparam int L7_N  = S_M - S_LAT;
    localparam int L8_N  = S_M - S_E;
    localparam int L9_N  = S_M - S_D;
    localparam int L10_N = S_M - 1;
    localparam int L5_TAP_G  = S_G - S_N - 1;
    localparam int L5_TAP_E0 = S_E0 - S_N - 1;
    localparam int L7_TAP_D  = S_D - S_LAT - 1;

    localparam logic [35:0] E2_ONE = 36'h1_0000_0000;

    logic        accept;
    logic [47:0] r_mu;
    logic [S_O:1] r_vld;

    // ---------------- control ----------------
    assign busy        = ~i_rst_n;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu <= MU_RESET;
        end else if (i_cfg_valid) begin
            r_mu <= i_cfg_data;
        end
    end

    // valid bits advance one stage per cycle alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_O-1:1], accept};
        end
    end

    // ---------------- stage 1: split into sign and magnitude ----------------
    logic        r1_pxn, r1_pyn, r1_vxn, r1_vyn, r1_zr;
    logic [31:0] r1_pxm, r1_pym, r1_vxm, r1_vym;

    always_ff @(posedge i_clk) begin
        r1_pxn <= i_pos_x[31];
        r1_pyn <= i_pos_y[31];
        r1_vxn <= i_vel_x[31];
        r1_vyn <= i_vel_y[31];
        r1_pxm <= abs32(i_pos_x);
        r1_pym <= abs32(i_pos_y);
        r1_vxm <= abs32(i_vel_x);
        r1_vym <= abs32(i_vel_y);
        r1_zr  <= (i_pos_x == 32'sd0) && (i_pos_y == 32'sd0);
    end

    // ---------------- stage 2: cross and square products ----------------
    logic        r2_s1, r2_s2, r2_pxn, r2_pyn, r2_vxn, r2_vyn;
    logic [31:0] r2_pxm, r2_pym, r2_vxm, r2_vym;
    logic [63:0] r2_p1, r2_p2, r2_q1, r2_q2;

    always_ff @(posedge i_clk) begin
        r2_p1  <= r1_pxm * r1_vym;
        r2_p2  <= r1_pym * r1_vxm;
        r2_q1  <= r1_pxm * r1_pxm;
        r2_q2  <= r1_pym * r1_pym;
        r2_s1  <= r1_pxn ^ r1_vyn;
        r2_s2  <= ~(r1_pyn ^ r1_vxn);
        r2_pxn <= r1_pxn;
        r2_pyn <= r1_pyn;
        r2_vxn <= r1_vxn;
        r2_vyn <= r1_vyn;
        r2_pxm <= r1_pxm;
        r2_pym <= r1_pym;
        r2_vxm <= r1_vxm;
        r2_vym <= r1_vym;
    end

    // ---------------- stage 3: angular momentum and radius squared ----------------
    t_sm         r3_h;
    logic [63:0] r3_rsq;
    logic        r3_pxn, r3_pyn, r3_vxn, r3_vyn;
    logic [31:0] r3_pxm, r3_pym, r3_vxm, r3_vym;

    always_ff @(posedge i_clk) begin
        r3_h   <= sm_add(r2_s1, r2_p1, r2_s2, r2_p2);
        r3_rsq <= r2_q1 + r2_q2;
        r3_pxn <= r2_pxn;
        r3_pyn <= r2_pyn;
        r3_vxn <= r2_vxn;
        r3_vyn <= r2_vyn;
        r3_pxm <= r2_pxm;
        r3_pym <= r2_pym;
        r3_vxm <= r2_vxm;
        r3_vym <= r2_vym;
    end

    // ---------------- semi-latus rectum: h^2 / mu ----------------
    logic [127:0] w_hh, w_lat_q;
    logic [31:0]  r_lat;
    logic         r_lat_sat;

    sv2oe_mul u_mul_hh (
        .i_clk  (i_clk),
        .i_a    (r3_h.mag),
        .i_b    (r3_h.mag),
        .o_prod (w_hh)
    );

    sv2oe_div u_div_lat (
        .i_clk (i_clk),
        .i_num (w_hh),
        .i_den ({16'd0, r_mu}),
        .o_quo (w_lat_q)
    );

    // drop the 32 fraction bits, saturate to the 32-bit field
    always_ff @(posedge i_clk) begin
        r_lat_sat <= |w_lat_q[127:64];
        r_lat     <= (|w_lat_q[127:64]) ? 32'hFFFF_FFFF : w_lat_q[63:32];
    end

    // ---------------- radius ----------------
    logic [31:0] w_root;

    sv2oe_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r3_rsq),
        .o_root (w_root)
    );

    // hold position magnitudes until the radius is ready
    logic [63:0] r_l1 [0:L1_N-1];
    always_ff @(posedge i_clk) begin
        r_l1[0] <= {r3_pxm, r3_pym};
        for (int i = 1; i < L1_N; i++) begin
            r_l1[i] <= r_l1[i-1];
        end
    end

    logic [31:0] r_l2 [0:L2_N-1];
    always_ff @(posedge i_clk) begin
        r_l2[0] <= w_root;
        for (int i = 1; i < L2_N; i++) begin
            r_l2[i] <= r_l2[i-1];
        end
    end

    // ---------------- mu * p / r terms ----------------
    logic [127:0] w_mx, w_my, w_tx, w_ty;

    sv2oe_mul u_mul_mx (
        .i_clk  (i_clk),
        .i_a    ({16'd0, r_mu}),
        .i_b    ({32'd0, r_l1[L1_N-1][63:32]}),
        .o_prod (w_mx)
    );

    sv2oe_mul u_mul_my (
        .i_clk  (i_clk),
        .i_a    ({16'd0, r_mu}),
        .i_b    ({32'd0, r_l1[L1_N-1][31:0]}),
        .o_prod (w_my)
    );

    sv2oe_div u_div_tx (
        .i_clk (i_clk),
        .i_num (w_mx),
        .i_den ({32'd0, r_l2[L2_N-1]}),
        .o_quo (w_tx)
    );

    sv2oe_div u_div_ty (
        .i_clk (i_clk),
        .i_num (w_my),
        .i_den ({32'd0, r_l2[L2_N-1]}),
        .o_quo (w_ty)
    );

    // ---------------- h * v terms ----------------
    // {hn, hm, vxm, vym, vxn, vyn, pxn, pyn}
    logic [132:0] r_l3 [0:L3_N-1];
    always_ff @(posedge i_clk) begin
        r_l3[0] <= {r3_h.neg, r3_h.mag, r3_vxm, r3_vym, r3_vxn, r3_vyn, r3_pxn, r3_pyn};
        for (int i = 1; i < L3_N; i++) begin
            r_l3[i] <= r_l3[i-1];
        end
    end

    logic [127:0] w_hvx, w_hvy;

    sv2oe_mul u_mul_hvy (
        .i_clk  (i_clk),
        .i_a    (r_l3[L3_N-1][131:68]),
        .i_b    ({32'd0, r_l3[L3_N-1][35:4]}),
        .o_prod (w_hvy)
    );

    sv2oe_mul u_mul_hvx (
        .i_clk  (i_clk),
        .i_a    (r_l3[L3_N-1][131:68]),
        .i_b    ({32'd0, r_l3[L3_N-1][67:36]}),
        .o_prod (w_hvx)
    );

    // {hn, vxn, vyn, pxn, pyn}
    logic [4:0] r_l4 [0:L4_N-1];
    always_ff @(posedge i_clk) begin
        r_l4[0] <= {r_l3[L3_N-1][132], r_l3[L3_N-1][3:0]};
        for (int i = 1; i < L4_N; i++) begin
            r_l4[i] <= r_l4[i-1];
        end
    end

    logic w_hn, w_vxn, w_vyn, w_pxn, w_pyn;
    assign {w_hn, w_vxn, w_vyn, w_pxn, w_pyn} = r_l4[L4_N-1];

    // ---------------- eccentricity vector ----------------
    t_sm r_ax, r_ay;

    always_ff @(posedge i_clk) begin
        r_ax <= sm_add(w_hn ^ w_vyn, w_hvy[95:32], ~w_pxn, w_tx[63:0]);
        r_ay <= sm_add(~(w_hn ^ w_vxn), w_hvx[95:32], ~w_pyn, w_ty[63:0]);
    end

    // scale both magnitudes below 2^60, then restore signs
    logic [63:0] any_mag, ax_sh, ay_sh;
    logic [2:0]  n_s;
    logic [63:0] r_nx, r_ny;
    logic [2:0]  r_ns;
    logic        r_nzero;

    assign any_mag = r_ax.mag | r_ay.mag;

    always_comb begin
        priority if (any_mag[63]) begin
            n_s = 3'd4;
        end else if (any_mag[62]) begin
            n_s = 3'd3;
        end else if (any_mag[61]) begin
            n_s = 3'd2;
        end else if (any_mag[60]) begin
            n_s = 3'd1;
        end else begin
            n_s = 3'd0;
        end
    end

    assign ax_sh = r_ax.mag >> n_s;
    assign ay_sh = r_ay.mag >> n_s;

    always_ff @(posedge i_clk) begin
        r_nx    <= r_ax.neg ? (~ax_sh + 64'd1) : ax_sh;
        r_ny    <= r_ay.neg ? (~ay_sh + 64'd1) : ay_sh;
        r_ns    <= n_s;
        r_nzero <= (any_mag == 64'd0);
    end

    // turn a vector in the left half plane by pi
    logic [63:0] r_cx, r_cy;
    logic [31:0] r_cz;

    always_ff @(posedge i_clk) begin
        r_cx <= r_nx[63] ? (~r_nx + 64'd1) : r_nx;
        r_cy <= r_nx[63] ? (~r_ny + 64'd1) : r_ny;
        r_cz <= r_nx[63] ? 32'h8000_0000 : 32'd0;
    end

    logic [63:0] w_gx;
    logic [31:0] w_gz, w_angle_sum;

    sv2oe_cordic u_cordic (
        .i_clk (i_clk),
        .i_x   (r_cx),
        .i_y   (r_cy),
        .i_z   (r_cz),
        .o_x   (w_gx),
        .o_z   (w_gz)
    );

    // round the angle to 16 bits
    assign w_angle_sum = w_gz + 32'h0000_8000;

    logic [15:0] r_l6 [0:L6_N-1];
    always_ff @(posedge i_clk) begin
        r_l6[0] <= w_angle_sum[31:16];
        for (int i = 1; i < L6_N; i++) begin
            r_l6[i] <= r_l6[i-1];
        end
    end

    // {zero vector, scale shift}
    logic [3:0] r_l5 [0:L5_N-1];
    always_ff @(posedge i_clk) begin
        r_l5[0] <= {r_nzero, r_ns};
        for (int i = 1; i < L5_N; i++) begin
            r_l5[i] <= r_l5[i-1];
        end
    end

    // ---------------- eccentricity: gain-corrected length / mu ----------------
    logic [127:0] w_g, r_gs, w_eq;
    logic [4:0]   gs_sh;

    sv2oe_mul u_mul_g (
        .i_clk  (i_clk),
        .i_a    (w_gx),
        .i_b    ({32'd0, INV_GAIN}),
        .o_prod (w_g)
    );

    assign gs_sh = 5'd16 - {2'd0, r_l5[L5_TAP_G][2:0]};

    always_ff @(posedge i_clk) begin
        r_gs <= w_g >> gs_sh;
    end

    sv2oe_div u_div_e (
        .i_clk (i_clk),
        .i_num (r_gs),
        .i_den ({16'd0, r_mu}),
        .o_quo (w_eq)
    );

    logic [17:0] r_ecc;
    logic        r_ecc_sat;
    logic        e_big, e_zero;

    assign e_big  = |w_eq[127:18];
    assign e_zero = r_l5[L5_TAP_E0][3];

    always_ff @(posedge i_clk) begin
        r_ecc_sat <= ~e_zero & e_big;
        if (e_zero) begin
            r_ecc <= '0;
        end else begin
            r_ecc <= e_big ? ECC_MAX : w_eq[17:0];
        end
    end

    logic [18:0] r_l8 [0:L8_N-1];
    always_ff @(posedge i_clk) begin
        r_l8[0] <= {r_ecc_sat, r_ecc};
        for (int i = 1; i < L8_N; i++) begin
            r_l8[i] <= r_l8[i-1];
        end
    end

    // ---------------- semi-major axis: p / |1 - e^2| ----------------
    logic [35:0] r_e2, r_den;
    logic        r_dneg, r_dpar;

    always_ff @(posedge i_clk) begin
        r_e2 <= r_ecc * r_ecc;
    end

    always_ff @(posedge i_clk) begin
        r_dneg <= r_e2 > E2_ONE;
        r_dpar <= r_e2 == E2_ONE;
        r_den  <= (r_e2 > E2_ONE) ? (r_e2 - E2_ONE) : (E2_ONE - r_e2);
    end

    logic [32:0] r_l7 [0:L7_N-1];
    always_ff @(posedge i_clk) begin
        r_l7[0] <= {r_lat_sat, r_lat};
        for (int i = 1; i < L7_N; i++) begin
            r_l7[i] <= r_l7[i-1];
        end
    end

    logic [127:0] w_aq;

    sv2oe_div u_div_a (
        .i_clk (i_clk),
        .i_num ({64'd0, r_l7[L7_TAP_D][31:0], 32'd0}),
        .i_den ({28'd0, r_den}),
        .o_quo (w_aq)
    );

    logic [1:0] r_l9 [0:L9_N-1];
    always_ff @(posedge i_clk) begin
        r_l9[0] <= {r_dneg, r_dpar};
        for (int i = 1; i < L9_N; i++) begin
            r_l9[i] <= r_l9[i-1];
        end
    end

    logic r_l10 [0:L10_N-1];
    always_ff @(posedge i_clk) begin
        r_l10[0] <= r1_zr;
        for (int i = 1; i < L10_N; i++) begin
            r_l10[i] <= r_l10[i-1];
        end
    end

    // ---------------- output stage ----------------
    logic [63:0] m_mag;
    logic        m_neg, m_par, m_zr, m_zero, m_lat_sat, m_ecc_sat;
    logic [31:0] m_lat;
    logic [17:0] m_ecc;
    logic [15:0] m_ang;
    logic [32:0] neg_mag;

    logic [15:0] n_angle;
    logic [31:0] n_lat, n_semi;
    logic [17:0] n_ecc;
    t_status     n_status;
    logic        semi_sat;

    assign m_mag     = w_aq[63:0];
    assign {m_neg, m_par} = r_l9[L9_N-1];
    assign m_zr      = r_l10[L10_N-1];
    assign m_zero    = r_l5[L5_N-1][3];
    assign m_lat_sat = r_l7[L7_N-1][32];
    assign m_lat     = r_l7[L7_N-1][31:0];
    assign m_ecc_sat = r_l8[L8_N-1][18];
    assign m_ecc     = r_l8[L8_N-1][17:0];
    assign m_ang     = r_l6[L6_N-1];
    assign neg_mag   = 33'h1_0000_0000 - ((m_mag > 64'h8000_0000) ? 33'h0_8000_0000
                                                                   : m_mag[32:0]);

    always_comb begin
        n_angle  = '0;
        n_lat    = '0;
        n_ecc    = '0;
        n_semi   = '0;
        n_status = ST_OK;
        semi_sat = 1'b0;
        priority if (r_mu == 48'd0) begin
            n_status = ST_ZERO_MU;
        end else if (m_zr) begin
            n_status = ST_ZERO_RADIUS;
        end else begin
            n_angle = m_zero ? 16'd0 : m_ang;
            n_lat   = m_lat;
            n_ecc   = m_ecc;
            if (m_par) begin
                n_status = ST_PARABOLIC;
            end else begin
                if (m_neg) begin
                    semi_sat = m_mag > 64'h8000_0000;
                    n_semi   = neg_mag[31:0];
                end else begin
                    semi_sat = m_mag > 64'h7FFF_FFFF;
                    n_semi   = semi_sat ? 32'h7FFF_FFFF : m_mag[31:0];
                end
                n_status = (m_lat_sat | m_ecc_sat | semi_sat) ? ST_SAT : ST_OK;
            end
        end
    end

    logic [15:0] r_o_angle;
    logic [31:0] r_o_lat, r_o_semi;
    logic [17:0] r_o_ecc;
    t_status     r_o_status;

    always_ff @(posedge i_clk) begin
        r_o_angle  <= n_angle;
        r_o_lat    <= n_lat;
        r_o_ecc    <= n_ecc;
        r_o_semi   <= n_semi;
        r_o_status <= n_status;
    end

    assign o_valid           = r_vld[S_O];
    assign o_periapsis_angle = r_o_angle;
    assign o_latus_rectum    = r_o_lat;
    assign o_eccentricity    = r_o_ecc;
    assign o_major_semi_axis = r_o_semi;
    assign o_status          = r_o_status;

endmodule

// ===== hw/rtl/sv2oe_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the orbit elements block, bound to the top level.
// Depends on sv2oe_pkg for latency and status codes.
module sv2oe_chk import sv2oe_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_periapsis_angle,
    input logic        [31:0] o_latus_rectum,
    input logic        [17:0] o_eccentricity,
    input logic signed [31:0] o_major_semi_axis,
    input logic        [2:0]  o_status
);

    // every result traces back to a transfer exactly one latency earlier
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, S_O))
        else $error("result without a matching transfer");

    a_zero_mu_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ZERO_MU) |->
            (o_periapsis_angle == 16'sd0 && o_latus_rectum == 32'd0 &&
             o_eccentricity == 18'd0 && o_major_semi_axis == 32'sd0))
        else $error("zero mu result carries nonzero fields");

    a_parabolic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_PARABOLIC) |->
            (o_eccentricity == 18'd65536 && o_major_semi_axis == 32'sd0))
        else $error("parabolic flag inconsistent with fields");

    a_ellipse_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK && o_eccentricity < 18'd65536) |->
            !o_major_semi_axis[31])
        else $error("closed orbit with negative semi-major axis");

endmodule

bind state_vector_to_orbit_elements sv2oe_chk u_chk (.*);
